[hdl/permutation_power_transposer_defines.svh]
// Assertion helpers for the transposer.
`ifndef PERMUTATION_POWER_TRANSPOSER_DEFINES_SVH
`define PERMUTATION_POWER_TRANSPOSER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define PPT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define PPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PPT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PPT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[hdl/ppt_pkg.sv]
package ppt_pkg;

   localparam int MAX_BLOCK_DEFAULT = 256;

   localparam int POS_W    = 8;
   localparam int CHAR_W   = 8;
   localparam int ROUNDS_W = 32;
   localparam int LEN_W    = 9;
   localparam int COUNT_W  = 9;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_BLOCK_LENGTH_ADDR = 2'd0;
   localparam logic [LEN_W-1:0]      BLOCK_LENGTH_RESET    = 9'd256;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_PLACE = 1'b1
   } op_type;

   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] remainder;
   } mod_result_type;

endpackage

[hdl/ppt_key_ram.sv]
module ppt_key_ram
   import ppt_pkg::*;
#(
   parameter int DEPTH  = MAX_BLOCK_DEFAULT,
   parameter int ADDR_W = $clog2(MAX_BLOCK_DEFAULT)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [POS_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [POS_W-1:0]  rd_data
);

   logic [POS_W-1:0] key_mem [DEPTH];
   logic [POS_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= key_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/ppt_mod_unit.sv]
module ppt_mod_unit
   import ppt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [ROUNDS_W-1:0] dividend,
   input  logic [COUNT_W-1:0]  divisor,
   output mod_result_type      result
);

   localparam int CNT_W = $clog2(ROUNDS_W);
   localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(ROUNDS_W - 1);

   logic                run_ff,  run_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff,  cnt_in;
   logic [ROUNDS_W-1:0] quo_ff,  quo_in;
   logic [COUNT_W-1:0]  rem_ff,  rem_in;
   logic [COUNT_W-1:0]  dvs_ff,  dvs_in;
   logic [COUNT_W:0]    trial;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   assign trial = {rem_ff, quo_ff[ROUNDS_W-1]};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         quo_in = {quo_ff[ROUNDS_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = COUNT_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[COUNT_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign result.done      = done_ff;
   assign result.remainder = rem_ff;

endmodule

[hdl/permutation_power_transposer.sv]
// Repeated transposition by a key permutation. After reset the block clears
// every entry of its walk-mark memory, one entry per cycle (the memory is as
// deep as the key table); busy stays high meanwhile and no transaction is
// taken. A load transaction (op 0) writes one key table entry and completes
// in the accepting cycle; busy never rises. A character transaction (op 1)
// whose position lies inside the block walks the key from that position, one
// key table read per cycle, and marks each node it takes. The walk stops when
// it covers the block, when the key leaves the block or when it comes back to
// a marked node. Call the number of nodes on the walk L. A bit-serial
// remainder unit then reduces rounds modulo L. A second walk over the same L
// nodes clears the marks and picks the node that lies (rounds mod L) steps
// from the source. The single read port of the key table and the
// one-bit-per-cycle remainder unit set how long busy stays high. The strobe
// rsp_valid comes in the cycle after the last busy cycle, and busy is already
// low in the strobe cycle. The receiver cannot stall: rsp_valid,
// rsp_dest_position and rsp_char_out are valid for exactly one cycle and must
// be taken then. Character transactions outside the block give no result and
// busy does not rise. Write block_length (byte address 0) only while no
// character transaction is in progress. Reading a key entry that was never
// loaded yields an arbitrary destination.
`include "permutation_power_transposer_defines.svh"

module permutation_power_transposer
   import ppt_pkg::*;
#(
   parameter int MAX_BLOCK = MAX_BLOCK_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_op,
   input  logic [POS_W-1:0]      req_position,
   input  logic [POS_W-1:0]      req_key_value,
   input  logic [CHAR_W-1:0]     req_char_in,
   input  logic [ROUNDS_W-1:0]   req_rounds,
   // result channel
   output logic                  rsp_valid,
   output logic [POS_W-1:0]      rsp_dest_position,
   output logic [CHAR_W-1:0]     rsp_char_out,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Positions are 8 bits wide, so the table never needs more than 256 entries.
   localparam int KEY_DEPTH = (MAX_BLOCK > 256) ? 256 : MAX_BLOCK;
   localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int MAX_CLIP  = (MAX_BLOCK > 511) ? 511 : MAX_BLOCK;
   localparam logic [LEN_W-1:0] MAX_CLIP_LEN = LEN_W'(MAX_CLIP);
   localparam logic [POS_W-1:0] KEY_LAST     = POS_W'(KEY_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DIV,
      ST_STEP
   } state_type;

   state_type           state_ff,   state_in;
   logic [LEN_W-1:0]    bl_ff,      bl_in;
   logic [POS_W-1:0]    node_ff,    node_in;
   logic [POS_W-1:0]    pos_ff,     pos_in;
   logic [CHAR_W-1:0]   char_ff,    char_in;
   logic [ROUNDS_W-1:0] rounds_ff,  rounds_in;
   logic [COUNT_W-1:0]  count_ff,   count_in;
   logic [COUNT_W-1:0]  steps_ff,   steps_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [POS_W-1:0]    dest_ff,    dest_in;
   logic                mark_rd_ff;

   // One mark per key table entry: set while a node is on the current walk.
   logic                mark_mem [KEY_DEPTH];

   logic                accept;
   logic                csr_write;
   logic [LEN_W-1:0]    eff_len;
   logic                load_wr;
   logic                place_go;
   logic [POS_W-1:0]    key_rd;
   logic [COUNT_W-1:0]  count_next;
   logic                walk_last;
   logic                mark_we;
   logic                mark_wd;
   logic                div_start;
   mod_result_type      mod_res;

   // Register port: zero wait states.
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign prdata    = (paddr == REG_BLOCK_LENGTH_ADDR) ? CSR_DATA_W'(bl_ff) : '0;

   // Clamp the block length to MAX_BLOCK, and to 511 at most.
   assign eff_len = (bl_ff > MAX_CLIP_LEN) ? MAX_CLIP_LEN : bl_ff;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start & ~busy;
   assign load_wr  = accept & (op_type'(req_op) == OP_LOAD)
                   & ({1'b0, req_position} < MAX_CLIP_LEN);
   assign place_go = accept & (op_type'(req_op) == OP_PLACE)
                   & ({1'b0, req_position} < eff_len);

   // Read data always belongs to node_ff: the address is the next node.
   ppt_key_ram #(
      .DEPTH  (KEY_DEPTH),
      .ADDR_W (KEY_AW)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (req_position[KEY_AW-1:0]),
      .wr_data (req_key_value),
      .rd_addr (node_in[KEY_AW-1:0]),
      .rd_data (key_rd)
   );

   // The divisor is the final walk length, taken as the walk ends.
   ppt_mod_unit u_mod_unit (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rounds_ff),
      .divisor  (count_in),
      .result   (mod_res)
   );

   // Mark memory: read beside the key table at the same address, so the mark
   // of node_ff is ready together with its key entry.
   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[node_ff[KEY_AW-1:0]] <= mark_wd;
      end
      mark_rd_ff <= mark_mem[node_in[KEY_AW-1:0]];
   end

   // Once node_ff is on the walk, stop when the block is covered, when the key
   // leaves the block, or when the entry points back at node_ff itself (its
   // mark is written on the same edge and could not be read back in time).
   assign count_next = count_ff + 1'b1;
   assign walk_last  = (count_next >= eff_len)
                     | ({1'b0, key_rd} >= eff_len)
                     | (key_rd == node_ff);

   // Set marks during the walk, clear them everywhere else.
   assign mark_wd = (state_ff == ST_WALK);

   always_comb begin
      state_in   = state_ff;
      bl_in      = bl_ff;
      node_in    = node_ff;
      pos_in     = pos_ff;
      char_in    = char_ff;
      rounds_in  = rounds_ff;
      count_in   = count_ff;
      steps_in   = steps_ff;
      rsp_vld_in = 1'b0;
      dest_in    = dest_ff;
      div_start  = 1'b0;
      mark_we    = 1'b0;

      if (csr_write && (paddr == REG_BLOCK_LENGTH_ADDR)) begin
         bl_in = pwdata[LEN_W-1:0];
      end

      case (state_ff)
         ST_CLEAR: begin
            // Wipe one mark per cycle after reset.
            mark_we = 1'b1;
            if (node_ff == KEY_LAST) begin
               state_in = ST_IDLE;
            end else begin
               node_in = node_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (place_go) begin
               state_in  = ST_WALK;
               node_in   = req_position;
               pos_in    = req_position;
               char_in   = req_char_in;
               rounds_in = req_rounds;
               count_in  = '0;
            end
         end
         ST_WALK: begin
            if (mark_rd_ff) begin
               // node_ff is already on the walk: the loop is closed.
               state_in  = ST_DIV;
               div_start = 1'b1;
               node_in   = pos_ff;
            end else begin
               mark_we  = 1'b1;
               count_in = count_next;
               if (walk_last) begin
                  // Hand the cycle length to the remainder unit, rewind to source.
                  state_in  = ST_DIV;
                  div_start = 1'b1;
                  node_in   = pos_ff;
               end else begin
                  node_in = key_rd;
               end
            end
         end
         ST_DIV: begin
            node_in = pos_ff;
            if (mod_res.done) begin
               // Pick the node when this many walk nodes are still left.
               state_in = ST_STEP;
               steps_in = count_ff - mod_res.remainder;
            end
         end
         ST_STEP: begin
            // Walk the same nodes again, clear each mark, grab the destination.
            mark_we = 1'b1;
            if (count_ff == steps_ff) begin
               dest_in = node_ff;
            end
            if (count_ff == COUNT_W'(1)) begin
               state_in   = ST_IDLE;
               rsp_vld_in = 1'b1;
            end else begin
               node_in  = key_rd;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      char_ff   <= char_in;
      rounds_ff <= rounds_in;
      count_ff  <= count_in;
      steps_ff  <= steps_in;
      dest_ff   <= dest_in;
      if (reset) begin
         state_ff   <= ST_CLEAR;
         node_ff    <= '0;
         bl_ff      <= BLOCK_LENGTH_RESET;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         node_ff    <= node_in;
         bl_ff      <= bl_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_dest_position = dest_ff;
   assign rsp_char_out      = char_ff;

   // At most one result per transaction: a strobe never repeats.
   `PPT_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_vld_ff, !rsp_vld_ff)
   // The remainder unit finishes only while the sequencer waits for it.
   `PPT_ASSERT_IMP(a_div_done_in_div, clock, reset, mod_res.done, state_ff == ST_DIV)
   // The cycle length never exceeds the block.
   `PPT_ASSERT_IMP(a_len_in_block, clock, reset, state_ff == ST_DIV, count_ff <= eff_len)

endmodule

[tb/tb.sv]
module tb;
   import ppt_pkg::*;

   // Key table depth as built; block lengths above it act as this value.
   localparam int SPAN          = MAX_BLOCK_DEFAULT;
   // Quiet cycles allowed before the run is declared hung.
   localparam int STALL_LIMIT   = 4000;
   // Cycles to wait once idle, before a register write and at the end.
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      op_type                op;
      logic [POS_W-1:0]      position;
      logic [POS_W-1:0]      key_value;
      logic [CHAR_W-1:0]     char_in;
      logic [ROUNDS_W-1:0]   rounds;
   } transposer_command;

   typedef struct packed {
      logic [POS_W-1:0]      dest_position;
      logic [CHAR_W-1:0]     char_out;
   } placement;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   op_type                req_op = OP_LOAD;
   logic [POS_W-1:0]      req_position = '0;
   logic [POS_W-1:0]      req_key_value = '0;
   logic [CHAR_W-1:0]     req_char_in = '0;
   logic [ROUNDS_W-1:0]   req_rounds = '0;
   logic                  rsp_valid;
   logic [POS_W-1:0]      rsp_dest_position;
   logic [CHAR_W-1:0]     rsp_char_out;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Commands waiting to be sent, and placements the block still owes us.
   transposer_command commands_pending[$];
   placement          placements_due[$];

   // Predictor state: key table and block length as the block should hold them.
   logic [POS_W-1:0] key_model [SPAN];
   logic [LEN_W-1:0] block_len_model = BLOCK_LENGTH_RESET;

   // Stimulus-side view of the table. It runs ahead of the block, which is
   // safe because commands are applied strictly in queue order.
   logic [POS_W-1:0] gen_key [SPAN];
   bit   [SPAN-1:0]  gen_written = '0;
   bit   [SPAN-1:0]  gen_fresh = '0;
   bit   [SPAN-1:0]  gen_target_taken = '0;
   logic [LEN_W-1:0] gen_len = BLOCK_LENGTH_RESET;
   bit               gen_perm_mode = 1'b0;
   int               queued_items = 0;

   transposer_command cmd;
   placement          due;
   logic              took_item = 1'b0;
   int                burst_left = 1;
   int                gap_left = 0;
   int                idle_cycles = 0;
   int                mismatch_count = 0;
   int                csr_faults = 0;

   permutation_power_transposer dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_position      (req_position),
      .req_key_value     (req_key_value),
      .req_char_in       (req_char_in),
      .req_rounds        (req_rounds),
      .rsp_valid         (rsp_valid),
      .rsp_dest_position (rsp_dest_position),
      .rsp_char_out      (rsp_char_out),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #10 clock = ~clock;

   // Clamp the register value to the table depth.
   function automatic int active_span(input logic [LEN_W-1:0] len);
      return (len > SPAN) ? SPAN : int'(len);
   endfunction

   // Follow the key from source until the walk repeats a node, leaves the
   // block or covers the whole block; the visited count is the cycle length.
   // Then pick the node (rounds mod length) steps along the walk.
   function automatic logic [POS_W-1:0] cycle_destination(input logic [POS_W-1:0] source,
                                                          input logic [ROUNDS_W-1:0] rounds);
      logic [POS_W-1:0] trail [SPAN];
      bit   [SPAN-1:0]  seen;
      int               span;
      int               count;
      int               node;
      span  = active_span(block_len_model);
      seen  = '0;
      count = 0;
      node  = source;
      while (1) begin
         trail[count] = POS_W'(node);
         seen[node]   = 1'b1;
         count++;
         if (count >= span) break;
         node = key_model[node];
         if (node >= span || seen[node]) break;
      end
      return trail[rounds % ROUNDS_W'(count)];
   endfunction

   // Trace the same walk on the stimulus-side table and return the first node
   // whose entry the block would read but that is not loaded yet (or, when
   // building a permutation, not loaded during this phase). -1 when clean.
   function automatic int first_unloaded_node(input int source);
      bit [SPAN-1:0] seen;
      int            span;
      int            count;
      int            node;
      span  = active_span(gen_len);
      seen  = '0;
      count = 0;
      node  = source;
      while (1) begin
         seen[node] = 1'b1;
         count++;
         if (count >= span) return -1;
         if (gen_perm_mode ? !gen_fresh[node] : !gen_written[node]) return node;
         node = gen_key[node];
         if (node >= span || seen[node]) return -1;
      end
   endfunction

   // When building a permutation, take a target nobody points at yet, so
   // the loaded entries stay one-to-one; otherwise mostly stay in the block.
   function automatic logic [POS_W-1:0] pick_target();
      int span;
      int first;
      int i;
      span = active_span(gen_len);
      if (gen_perm_mode && span > 0) begin
         first = $urandom_range(0, span - 1);
         for (i = 0; i < span; i++)
            if (!gen_target_taken[(first + i) % span]) return POS_W'((first + i) % span);
      end
      if (span > 0 && $urandom_range(0, 3) != 0) return POS_W'($urandom_range(0, span - 1));
      return POS_W'($urandom_range(0, 255));
   endfunction

   task automatic queue_load(input logic [POS_W-1:0] pos, input logic [POS_W-1:0] target);
      commands_pending.push_back('{OP_LOAD, pos, target, CHAR_W'($urandom), $urandom});
      gen_key[pos]             = target;
      gen_written[pos]         = 1'b1;
      gen_fresh[pos]           = 1'b1;
      gen_target_taken[target] = 1'b1;
      queued_items++;
   endtask

   // Queue one character transaction, loading first every key entry its walk
   // would touch that is still missing.
   task automatic queue_place(input logic [POS_W-1:0] pos, input logic [CHAR_W-1:0] ch,
                              input logic [ROUNDS_W-1:0] rounds);
      int gap_node;
      if (pos < active_span(gen_len)) begin
         gap_node = first_unloaded_node(pos);
         while (gap_node >= 0) begin
            queue_load(POS_W'(gap_node), pick_target());
            gap_node = first_unloaded_node(pos);
         end
      end
      commands_pending.push_back('{OP_PLACE, pos, POS_W'($urandom), ch, rounds});
      queued_items++;
   endtask

   // Wait until every command is taken, every placement has come back and the
   // block is idle, then let it settle.
   task automatic drain_pipeline();
      @(posedge clock);
      while (commands_pending.size() != 0 || start || busy || placements_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write block_length with junk above the register width, read it back,
   // and start a new stimulus phase at that length.
   task automatic enter_phase(input logic [LEN_W-1:0] len, input bit perm);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= REG_BLOCK_LENGTH_ADDR;
      pwdata  <= {(CSR_DATA_W - LEN_W)'($urandom), len};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      block_len_model = len;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[LEN_W-1:0] !== len) begin
         $error("block_length: expected %0d, actual %0d", len, prdata[LEN_W-1:0]);
         csr_faults++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      gen_len          = len;
      gen_perm_mode    = perm;
      gen_fresh        = '0;
      gen_target_taken = '0;
   endtask

   // One random phase: mostly character transactions over a key that is
   // built as needed, with a few stray loads mixed in to break it.
   task automatic run_phase(input logic [LEN_W-1:0] len, input bit perm, input int budget);
      int                  span;
      int                  stop_at;
      logic [POS_W-1:0]    pos;
      logic [ROUNDS_W-1:0] rounds;
      enter_phase(len, perm);
      span    = active_span(len);
      stop_at = queued_items + budget;
      while (queued_items < stop_at) begin
         if ($urandom_range(0, 99) < (perm ? 6 : 15)) begin
            queue_load(POS_W'($urandom), perm ? POS_W'($urandom) : pick_target());
         end else begin
            if (span > 0 && $urandom_range(0, 7) != 0) pos = POS_W'($urandom_range(0, span - 1));
            else pos = POS_W'($urandom);
            case ($urandom_range(0, 7))
               0: begin
                  rounds = '0;
               end
               1: begin
                  rounds = '1;
               end
               2, 3: begin
                  rounds = ROUNDS_W'($urandom_range(0, 2 * span + 2));
               end
               default: begin
                  rounds = $urandom;
               end
            endcase
            queue_place(pos, CHAR_W'($urandom), rounds);
         end
      end
      drain_pipeline();
   endtask

   // Driver: hold a command until it is taken, then advance to the next one
   // or drop start for a gap. Bursts and gaps have random lengths.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took_item) begin
         if (gap_left > 0 || commands_pending.size() == 0) begin
            start <= 1'b0;
            if (gap_left > 0) gap_left = gap_left - 1;
         end else begin
            cmd = commands_pending.pop_front();
            start         <= 1'b1;
            req_op        <= cmd.op;
            req_position  <= cmd.position;
            req_key_value <= cmd.key_value;
            req_char_in   <= cmd.char_in;
            req_rounds    <= cmd.rounds;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left = burst_left - 1;
            end
         end
      end
   end

   // Monitor: check the result strobe against the oldest placement owed, then
   // fold an accepted transaction into the predictor.
   always @(posedge clock) begin
      if (reset) begin
         took_item <= 1'b0;
      end else begin
         took_item <= start && !busy;
         if (rsp_valid) begin
            if (placements_due.size() == 0) begin
               $error("result with none owed: dest_position %0d, char_out %0d",
                      rsp_dest_position, rsp_char_out);
               mismatch_count++;
            end else begin
               due = placements_due.pop_front();
               if (rsp_dest_position !== due.dest_position) begin
                  $error("dest_position: expected %0d, actual %0d",
                         due.dest_position, rsp_dest_position);
                  mismatch_count++;
               end
               if (rsp_char_out !== due.char_out) begin
                  $error("char_out: expected %0d, actual %0d", due.char_out, rsp_char_out);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            if (req_op == OP_LOAD)
               key_model[req_position] = req_key_value;
            else if (req_position < active_span(block_len_model))
               placements_due.push_back('{cycle_destination(req_position, req_rounds),
                                          req_char_in});
         end
      end
   end

   // Watchdog: any accepted transaction, result or register access resets it.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Four-entry block with one full cycle 0 -> 1 -> 2 -> 3 -> 0.
      enter_phase(LEN_W'(4), 1'b0);
      queue_load(8'd0, 8'd1);
      queue_load(8'd1, 8'd2);
      queue_load(8'd2, 8'd3);
      queue_load(8'd3, 8'd0);
      queue_place(8'd0, 8'h00, 32'd0);           // zero rounds stay put
      queue_place(8'd0, 8'hFF, 32'd1);
      queue_place(8'd3, 8'hA5, 32'hFFFF_FFFF);   // largest round count
      queue_place(8'd2, 8'h5A, 32'd5);
      queue_place(8'd4, 8'h11, 32'd1);           // just past the block
      queue_place(8'd255, 8'h22, 32'd7);         // far past the block
      // Break the permutation: entry 1 points to itself, so 0 has a tail.
      queue_load(8'd1, 8'd1);
      queue_place(8'd0, 8'h33, 32'd7);
      // Target outside the block ends the walk at once.
      queue_load(8'd2, 8'd200);
      queue_place(8'd2, 8'h44, 32'd3);
      queue_load(8'd255, 8'd255);                // load beyond the block
      drain_pipeline();

      // Single-entry block: the walk never reads the table.
      enter_phase(LEN_W'(1), 1'b0);
      queue_place(8'd0, 8'h55, 32'h8000_0000);
      queue_place(8'd1, 8'h66, 32'd2);
      drain_pipeline();

      // Empty block: no character transaction gives a result.
      enter_phase(LEN_W'(0), 1'b0);
      queue_place(8'd0, 8'h77, 32'd1);
      queue_load(8'd0, 8'd0);
      drain_pipeline();

      run_phase(LEN_W'(2), 1'b1, 20);
      run_phase(LEN_W'(1), 1'b0, 15);
      run_phase(LEN_W'(0), 1'b0, 15);
      run_phase(LEN_W'($urandom_range(3, 12)), 1'b1, 45);
      run_phase(LEN_W'($urandom_range(3, 12)), 1'b0, 45);
      run_phase(LEN_W'(16), 1'b1, 40);
      run_phase(LEN_W'(511), 1'b1, 90);
      run_phase(LEN_W'(257), 1'b0, 40);
      run_phase(LEN_W'($urandom_range(13, 64)), 1'b1, 55);
      run_phase(LEN_W'(255), 1'b1, 80);
      run_phase(LEN_W'(256), 1'b0, 30);
      run_phase(LEN_W'($urandom_range(1, 40)), 1'b1, 30);

      if (mismatch_count == 0 && csr_faults == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/ppt_pkg.sv
hdl/ppt_key_ram.sv
hdl/ppt_mod_unit.sv
hdl/permutation_power_transposer.sv
tb/tb.sv
